// File: rtl/mna_pkg.sv
package mna_pkg;

	localparam int NOTE_W    = 7;
	localparam int COUNT_W   = 13;
	localparam int OFFSET_W  = 12;
	localparam int ELAPSED_W = 16;
	localparam int DIV_W     = 16;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int SEMITONES = 12;

	localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [1:0] MODE_TICK     = 2'd2;

	localparam logic [1:0] PAT_UP     = 2'd0;
	localparam logic [1:0] PAT_DOWN   = 2'd1;
	localparam logic [1:0] PAT_UPDOWN = 2'd2;

	localparam logic [2:0] REG_PATTERN     = 3'd0;
	localparam logic [2:0] REG_OCT_RISES   = 3'd1;
	localparam logic [2:0] REG_OCT_COUNT   = 3'd2;
	localparam logic [2:0] REG_STEP_PERIOD = 3'd3;
	localparam logic [2:0] REG_FIRST_STEP  = 3'd4;

	localparam logic [1:0]           RST_PATTERN    = PAT_UP;
	localparam logic                 RST_OCT_RISES  = 1'b1;
	localparam logic [3:0]           RST_OCT_COUNT  = 4'd1;
	localparam logic [ELAPSED_W-1:0] RST_STEP       = 16'd6615;
	localparam logic [ELAPSED_W-1:0] RST_FIRST_STEP = 16'd6615;

	typedef struct packed {
		logic              start;
		logic              remove;
		logic [NOTE_W-1:0] note;
	} notes_req_t;

endpackage

// File: rtl/mna_if.sv
interface mna_in_if import mna_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [NOTE_W-1:0]  note_number;
	logic [COUNT_W-1:0] sample_count;

	modport source (output valid, output mode, output note_number, output sample_count,
		input ready);
	modport sink (input valid, input mode, input note_number, input sample_count,
		output ready);
endinterface

interface mna_out_if import mna_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                is_note_on;
	logic [NOTE_W-1:0]   out_note;
	logic [OFFSET_W-1:0] sample_offset;
	logic                last_of_run;

	modport source (output valid, output is_note_on, output out_note, output sample_offset,
		output last_of_run, input ready);
	modport sink (input valid, input is_note_on, input out_note, input sample_offset,
		input last_of_run, output ready);
endinterface

// File: rtl/mna_div.sv
module mna_div import mna_pkg::*; #(
	parameter int DW = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW-1:0]    dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             busy,
	output logic [DW-1:0]    quot,
	output logic [DIV_W-1:0] rem
);

	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0]  cnt_q;
	logic [DW-1:0]    q_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             take;

	// one quotient bit per cycle, restoring
	assign trial = {r_q, q_q[DW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign take  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			q_q <= {q_q[DW-2:0], take};
			r_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

// File: rtl/mna_notes.sv
module mna_notes import mna_pkg::*; #(
	parameter int MAX_HELD = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  notes_req_t                 req,
	output logic                       busy,
	output logic [$clog2(MAX_HELD+1)-1:0] count,
	input  logic [((MAX_HELD > 1) ? $clog2(MAX_HELD) : 1)-1:0] rd_addr,
	output logic [NOTE_W-1:0]          rd_data
);

	localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int CW = $clog2(MAX_HELD + 1);

	typedef enum logic [2:0] {
		N_IDLE, N_SCAN, N_UP_RD, N_UP_WR, N_UP_FIN, N_DN_RD, N_DN_WR, N_DONE
	} nstate_t;

	nstate_t           st_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     p_q;
	logic [IW-1:0]     j_q;
	logic [NOTE_W-1:0] note_q;
	logic              rm_q;
	logic [CW-1:0]     count_q;

	logic [NOTE_W-1:0] mem [MAX_HELD];
	logic [NOTE_W-1:0] rdata_q;
	logic              we;
	logic [IW-1:0]     wa;
	logic [NOTE_W-1:0] wd;
	logic [IW-1:0]     ra;
	logic              last;

	assign last = (CW'(i_q) + 1'b1) == count_q;

	always_comb begin
		ra = rd_addr;
		we = 1'b0;
		wa = j_q;
		wd = rdata_q;
		unique case (st_q)
			N_IDLE: begin
				if (req.start) begin
					ra = '0;
					if (!req.remove && count_q == '0 && CW'(MAX_HELD) != '0) begin
						we = 1'b1;
						wa = '0;
						wd = req.note;
					end
				end
			end
			N_SCAN: begin
				ra = i_q + 1'b1;
				if (!rm_q && rdata_q < note_q && last) begin
					we = 1'b1;
					wa = IW'(count_q);
					wd = note_q;
				end
			end
			N_UP_RD: ra = j_q - 1'b1;
			N_UP_WR: we = 1'b1;
			N_UP_FIN: begin
				we = 1'b1;
				wa = p_q;
				wd = note_q;
			end
			N_DN_RD: ra = j_q + 1'b1;
			N_DN_WR: we = 1'b1;
			N_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= N_IDLE;
			count_q <= '0;
			i_q     <= '0;
			p_q     <= '0;
			j_q     <= '0;
			note_q  <= '0;
			rm_q    <= 1'b0;
		end else begin
			unique case (st_q)
				N_IDLE: begin
					if (req.start) begin
						note_q <= req.note;
						rm_q   <= req.remove;
						i_q    <= '0;
						if (req.remove) begin
							st_q <= (count_q == '0) ? N_DONE : N_SCAN;
						end else if (count_q >= CW'(MAX_HELD)) begin
							st_q <= N_DONE;
						end else if (count_q == '0) begin
							count_q <= count_q + 1'b1;
							st_q    <= N_DONE;
						end else begin
							st_q <= N_SCAN;
						end
					end
				end
				N_SCAN: begin
					if (rdata_q == note_q) begin
						if (!rm_q) begin
							st_q <= N_DONE;
						end else if (last) begin
							count_q <= count_q - 1'b1;
							st_q    <= N_DONE;
						end else begin
							j_q  <= i_q;
							st_q <= N_DN_RD;
						end
					end else if (rdata_q > note_q) begin
						if (rm_q) begin
							st_q <= N_DONE;
						end else begin
							p_q  <= i_q;
							j_q  <= IW'(count_q);
							st_q <= N_UP_RD;
						end
					end else if (last) begin
						// append at the top end
						if (!rm_q) begin
							count_q <= count_q + 1'b1;
						end
						st_q <= N_DONE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				N_UP_RD: st_q <= N_UP_WR;
				N_UP_WR: begin
					j_q  <= j_q - 1'b1;
					st_q <= ((j_q - 1'b1) == p_q) ? N_UP_FIN : N_UP_RD;
				end
				N_UP_FIN: begin
					count_q <= count_q + 1'b1;
					st_q    <= N_DONE;
				end
				N_DN_RD: st_q <= N_DN_WR;
				N_DN_WR: begin
					if ((CW'(j_q) + 2'd2) == count_q) begin
						count_q <= count_q - 1'b1;
						st_q    <= N_DONE;
					end else begin
						j_q  <= j_q + 1'b1;
						st_q <= N_DN_RD;
					end
				end
				N_DONE: st_q <= N_IDLE;
				default: st_q <= N_IDLE;
			endcase
		end
	end

	assign busy    = st_q != N_IDLE;
	assign count   = count_q;
	assign rd_data = rdata_q;

endmodule

// File: rtl/midi_note_arpeggiator_top.sv
// MIDI arpeggiator. Note-on and note-off transactions edit a sorted set of up to MAX_HELD
// held notes; tick transactions advance a sample counter and, when the step period runs
// out, give a note-off for the sounding note and a note-on for the next arpeggio note
// (up, down or up-down over octave_count octaves), both at the same offset in the tick
// block; last_of_run marks the final event of a tick. One transaction is taken at a time.
// A note edit reads the note memory once per scan step and reads and writes it once per
// shifted entry. A tick with a step and with notes held runs three divisions in turn on
// one bit-serial divider, then delivers its events one at a time, holding while the
// output is stalled. The user must write registers over the APB port only while the
// block is idle; the block itself does not enforce this.
module midi_note_arpeggiator_top import mna_pkg::*; #(
	parameter int MAX_HELD    = 16,
	parameter int MAX_OCTAVES = 8,
	parameter int MAX_BLOCK   = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	mna_in_if.sink            notes_in,
	mna_out_if.source         events_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IW   = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int CW   = $clog2(MAX_HELD + 1);
	localparam int LW   = $clog2(2 * MAX_HELD + 1);
	localparam int SCW  = $clog2(2 * MAX_HELD * MAX_OCTAVES);
	localparam int NBW  = $clog2(MAX_BLOCK + 1);
	localparam int CMPW = (NBW > COUNT_W) ? NBW : COUNT_W;
	localparam int OW   = (ELAPSED_W > NBW) ? ELAPSED_W : NBW;
	localparam int TOTW = OW + 1;
	localparam int DW   = (TOTW > SCW + 1) ? TOTW : SCW + 1;
	localparam int NW   = SCW + 6;

	typedef enum logic [3:0] {
		T_IDLE, T_NOTES, T_EVAL, T_DIV_IDX, T_ADDR, T_NOTE, T_DIV_CNT, T_DIV_EL,
		T_EMIT_OFF, T_EMIT_ON
	} tstate_t;

	// configuration registers
	logic [1:0]           pattern_q;
	logic                 oct_rises_q;
	logic [3:0]           oct_count_q;
	logic [ELAPSED_W-1:0] step_period_q;
	logic [ELAPSED_W-1:0] first_step_q;
	logic [2:0]           reg_idx;
	logic                 cfg_wr;

	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= RST_PATTERN;
			oct_rises_q   <= RST_OCT_RISES;
			oct_count_q   <= RST_OCT_COUNT;
			step_period_q <= RST_STEP;
			first_step_q  <= RST_FIRST_STEP;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PATTERN:     pattern_q     <= pwdata[1:0];
				REG_OCT_RISES:   oct_rises_q   <= pwdata[0];
				REG_OCT_COUNT:   oct_count_q   <= pwdata[3:0];
				REG_STEP_PERIOD: step_period_q <= pwdata[ELAPSED_W-1:0];
				REG_FIRST_STEP:  first_step_q  <= pwdata[ELAPSED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN:     prdata = APB_DW'(pattern_q);
			REG_OCT_RISES:   prdata = APB_DW'(oct_rises_q);
			REG_OCT_COUNT:   prdata = APB_DW'(oct_count_q);
			REG_STEP_PERIOD: prdata = APB_DW'(step_period_q);
			REG_FIRST_STEP:  prdata = APB_DW'(first_step_q);
			default:         prdata = '0;
		endcase
	end

	// sequencer state
	tstate_t              st_q;
	logic [SCW-1:0]       step_cnt_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [NOTE_W-1:0]    sounding_note_q;
	logic                 sounding_valid_q;
	logic [NBW-1:0]       n_q;
	logic [ELAPSED_W-1:0] period_q;
	logic [TOTW-1:0]      total_q;
	logic [NBW-1:0]       off_q;
	logic [NOTE_W-1:0]    off_note_q;
	logic                 off_pend_q;
	logic                 on_pend_q;
	logic [LW-1:0]        idx_q;
	logic [SCW-1:0]       oct_q;

	logic                  out_valid_q;
	logic                  out_on_q;
	logic [NOTE_W-1:0]     out_note_q;
	logic [OFFSET_W-1:0]   out_off_q;
	logic                  out_last_q;

	// note store and divider
	notes_req_t        nreq;
	logic              notes_busy;
	logic [CW-1:0]     held;
	logic [IW-1:0]     rd_addr;
	logic [NOTE_W-1:0] rd_data;

	logic             div_start;
	logic [DW-1:0]    div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic             div_busy;
	logic [DW-1:0]    div_quot;
	logic [DIV_W-1:0] div_rem;

	logic                 in_ready;
	logic                 in_accept;
	logic                 slot_free;
	logic                 emit;
	logic [CMPW-1:0]      cnt_ext;
	logic [NBW-1:0]       n_sat;
	logic [ELAPSED_W-1:0] period_sel;
	logic                 fire;
	logic [ELAPSED_W:0]   diff;
	logic [NBW-1:0]       off_calc;
	logic [3:0]           oct_n;
	logic [LW-1:0]        h_len;
	logic [LW-1:0]        seq_len;
	logic [LW+3:0]        seq_mod;
	logic [LW-1:0]        addr_full;
	logic                 rises;
	logic [NW-1:0]        oct12;
	logic [NW-1:0]        note_calc;
	logic                 note_ok;

	assign in_ready  = (st_q == T_IDLE) && !notes_busy;
	assign in_accept = notes_in.valid && in_ready;
	assign slot_free = !out_valid_q || events_out.ready;
	assign emit      = (st_q == T_EMIT_OFF || st_q == T_EMIT_ON) && slot_free;

	assign nreq.start  = in_accept &&
		(notes_in.mode == MODE_NOTE_ON || notes_in.mode == MODE_NOTE_OFF);
	assign nreq.remove = notes_in.mode == MODE_NOTE_OFF;
	assign nreq.note   = notes_in.note_number;

	assign cnt_ext = CMPW'(notes_in.sample_count);
	assign n_sat   = (cnt_ext > CMPW'(MAX_BLOCK)) ? NBW'(MAX_BLOCK) : NBW'(cnt_ext);

	always_comb begin
		period_sel = (step_cnt_q == '0) ? first_step_q : step_period_q;
		if (period_sel == '0) begin
			period_sel = ELAPSED_W'(1);
		end
	end

	assign fire = total_q >= TOTW'(period_q);

	// offset = clamp(period - elapsed, 0, n - 1)
	assign diff = {1'b0, period_q} - {1'b0, elapsed_q};
	always_comb begin
		if (diff[ELAPSED_W] || n_q == '0) begin
			off_calc = '0;
		end else if (OW'(diff[ELAPSED_W-1:0]) > OW'(n_q) - 1'b1) begin
			off_calc = n_q - 1'b1;
		end else begin
			off_calc = NBW'(diff[ELAPSED_W-1:0]);
		end
	end

	always_comb begin
		if (oct_count_q == '0) begin
			oct_n = 4'd1;
		end else if (oct_count_q > 4'(MAX_OCTAVES)) begin
			oct_n = 4'(MAX_OCTAVES);
		end else begin
			oct_n = oct_count_q;
		end
	end

	assign h_len   = LW'(held);
	assign seq_len = (pattern_q == PAT_UPDOWN) ? LW'(h_len << 1) : h_len;
	assign seq_mod = (LW+4)'(seq_len) * (LW+4)'(oct_n);

	always_comb begin
		case (pattern_q)
			PAT_DOWN:   addr_full = h_len - 1'b1 - idx_q;
			PAT_UPDOWN: addr_full = (idx_q < h_len) ? idx_q :
				LW'((h_len << 1) - 1'b1 - idx_q);
			default:    addr_full = idx_q;
		endcase
	end
	assign rd_addr = IW'(addr_full);

	always_comb begin
		case (pattern_q)
			PAT_DOWN:   rises = 1'b0;
			PAT_UPDOWN: rises = oct_rises_q;
			default:    rises = 1'b1;
		endcase
	end

	assign oct12     = NW'(oct_q) * NW'(SEMITONES);
	assign note_calc = rises ? NW'(rd_data) + oct12 : NW'(rd_data) - oct12;
	assign note_ok   = note_calc[NW-1:NOTE_W] == '0;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DW'(step_cnt_q);
		div_divisor  = DIV_W'(seq_len);
		unique case (st_q)
			T_EVAL: div_start = fire && held != '0;
			T_NOTE: begin
				div_start    = 1'b1;
				div_dividend = DW'(step_cnt_q) + 1'b1;
				div_divisor  = DIV_W'(seq_mod);
			end
			T_DIV_CNT: begin
				div_start    = !div_busy;
				div_dividend = DW'(total_q);
				div_divisor  = period_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q             <= T_IDLE;
			step_cnt_q       <= '0;
			elapsed_q        <= '0;
			sounding_note_q  <= '0;
			sounding_valid_q <= 1'b0;
			off_pend_q       <= 1'b0;
			on_pend_q        <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (events_out.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (in_accept) begin
						n_q      <= n_sat;
						period_q <= period_sel;
						total_q  <= TOTW'(elapsed_q) + TOTW'(n_sat);
						if (nreq.start) begin
							st_q <= T_NOTES;
						end else if (notes_in.mode == MODE_TICK) begin
							st_q <= T_EVAL;
						end
					end
				end
				T_NOTES: begin
					if (!notes_busy) begin
						st_q <= T_IDLE;
					end
				end
				T_EVAL: begin
					if (!fire) begin
						elapsed_q <= ELAPSED_W'(total_q);
						st_q      <= T_IDLE;
					end else begin
						off_q            <= off_calc;
						off_note_q       <= sounding_note_q;
						off_pend_q       <= sounding_valid_q;
						on_pend_q        <= 1'b0;
						sounding_valid_q <= 1'b0;
						if (held == '0) begin
							step_cnt_q <= '0;
							elapsed_q  <= '0;
							st_q       <= sounding_valid_q ? T_EMIT_OFF : T_IDLE;
						end else begin
							st_q <= T_DIV_IDX;
						end
					end
				end
				T_DIV_IDX: begin
					if (!div_busy) begin
						idx_q <= LW'(div_rem);
						oct_q <= SCW'(div_quot);
						st_q  <= T_ADDR;
					end
				end
				T_ADDR: st_q <= T_NOTE;
				T_NOTE: begin
					if (note_ok) begin
						sounding_note_q  <= NOTE_W'(note_calc);
						sounding_valid_q <= 1'b1;
						on_pend_q        <= 1'b1;
					end
					st_q <= T_DIV_CNT;
				end
				T_DIV_CNT: begin
					if (!div_busy) begin
						step_cnt_q <= SCW'(div_rem);
						st_q       <= T_DIV_EL;
					end
				end
				T_DIV_EL: begin
					if (!div_busy) begin
						elapsed_q <= ELAPSED_W'(div_rem);
						if (off_pend_q) begin
							st_q <= T_EMIT_OFF;
						end else if (on_pend_q) begin
							st_q <= T_EMIT_ON;
						end else begin
							st_q <= T_IDLE;
						end
					end
				end
				T_EMIT_OFF: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_on_q    <= 1'b0;
						out_note_q  <= off_note_q;
						out_off_q   <= OFFSET_W'(off_q);
						out_last_q  <= !on_pend_q;
						off_pend_q  <= 1'b0;
						st_q        <= on_pend_q ? T_EMIT_ON : T_IDLE;
					end
				end
				T_EMIT_ON: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_on_q    <= 1'b1;
						out_note_q  <= sounding_note_q;
						out_off_q   <= OFFSET_W'(off_q);
						out_last_q  <= 1'b1;
						on_pend_q   <= 1'b0;
						st_q        <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	mna_notes #(
		.MAX_HELD (MAX_HELD)
	) u_notes (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (nreq),
		.busy    (notes_busy),
		.count   (held),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mna_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign notes_in.ready           = in_ready;
	assign events_out.valid         = out_valid_q;
	assign events_out.is_note_on    = out_on_q;
	assign events_out.out_note      = out_note_q;
	assign events_out.sample_offset = out_off_q;
	assign events_out.last_of_run   = out_last_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held <= CW'(MAX_HELD))
		else $error("held note count above capacity");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_DIV_CNT && !div_busy) |=> (step_cnt_q < $past(seq_mod)))
		else $error("step counter not below pattern length");

endmodule
